// ===== rtl/core/wtpr_pkg.sv =====
// ----------------------------------------------------------------------------
// wtpr_pkg
// Shared types and constants of the write-tracking partial refresh unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wtpr_pkg;

	// Field and register widths.
	localparam int unsigned ROW_W   = 17;
	localparam int unsigned DIVS_W  = 18;
	localparam int unsigned IVL_W   = 16;
	localparam int unsigned RANKS_W = 4;
	localparam int unsigned CHAN_W  = 4;
	localparam int unsigned RANK_W  = 3;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;

	// Input word operation codes.
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_ACCESS = 1'b1;

	// Configuration register indexes (paddr[4:2]).
	localparam logic [2:0] REG_INTERVAL  = 3'd0;
	localparam logic [2:0] REG_NUM_RANKS = 3'd1;
	localparam logic [2:0] REG_NUM_ROWS  = 3'd2;
	localparam logic [2:0] REG_ROWS_BLK  = 3'd3;
	localparam logic [2:0] REG_CHANNEL   = 3'd4;

	// Hard limit on commands per refresh opportunity.
	localparam int unsigned RANK_LIMIT = 8;

	// Result of the row divider handed to the sequencer.
	typedef struct packed {
		logic             done;
		logic [ROW_W-1:0] quot;
		logic [ROW_W-1:0] rem;
	} wtpr_div_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/wtpr_ram.sv =====
// ----------------------------------------------------------------------------
// wtpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wtpr_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 4,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/wtpr_div.sv =====
// ----------------------------------------------------------------------------
// wtpr_div
// Restoring divider that splits a row into block number and block offset,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wtpr_div
	import wtpr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ROW_W-1:0]  dividend,
	input  wire logic [DIVS_W-1:0] divisor,
	output wtpr_div_res_t          res
);

	localparam int unsigned CNT_W = $clog2(ROW_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROW_W - 1);

	logic [DIVS_W-1:0] rem_q;
	logic [ROW_W-1:0]  quo_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIVS_W:0]   trial;
	logic [DIVS_W:0]   diff;
	logic              fits;

	// Trial subtraction of one step.
	always_comb begin
		trial = {rem_q, quo_q[ROW_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Partial remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[ROW_W-2:0], fits};
		end
	end

	// The remainder never exceeds the dividend, so it fits the row width.
	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q[ROW_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/write_tracking_partial_refresh_unit.sv =====
// ----------------------------------------------------------------------------
// write_tracking_partial_refresh_unit
// Refresh scheduler that skips row slots beyond the furthest accessed offset
// of each block.
// ----------------------------------------------------------------------------
// A tick word that does not reach the refresh interval leaves the unit idle,
// and the next word is taken in the following cycle. An access word, and a
// tick that opens a refresh opportunity, split the row or slot into block and
// offset through a bit-serial divider and then read the block's high-offset
// entry in the tracking RAM, which an access writes back when its offset is higher;
// a refresh opportunity that hits then sends one command word per rank,
// one per cycle while the consumer takes them. One word is in work at a time.
// The tracking RAM needs no clearing pass: a valid bit per block makes an
// unwritten entry read as zero right after reset.
`default_nettype none

module write_tracking_partial_refresh_unit
	import wtpr_pkg::*;
#(
	parameter int unsigned NUM_BLOCKS = 4,
	parameter int unsigned MAX_RANKS  = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration port.
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	// Input words.
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic              op,
	input  wire logic [ROW_W-1:0]  row,
	// Refresh command words.
	output logic                   ref_valid,
	input  wire logic              ref_ready,
	output logic      [CHAN_W-1:0] channel,
	output logic      [RANK_W-1:0] rank,
	output logic                   last
);

	localparam int unsigned BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int unsigned RANK_CAP = (MAX_RANKS < RANK_LIMIT) ? MAX_RANKS : RANK_LIMIT;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [IVL_W-1:0]   ivl_q;
	logic [RANKS_W-1:0] nranks_q;
	logic [DIVS_W-1:0]  nrows_q;
	logic [DIVS_W-1:0]  rpb_q;
	logic [CHAN_W-1:0]  chan_q;

	// Scheduler state.
	logic [IVL_W-1:0]   icnt_q;
	logic [ROW_W-1:0]   slot_q;
	logic [NUM_BLOCKS-1:0] vld_q;

	// Per-word working registers.
	logic               op_q;
	logic [BW-1:0]      blk_q;
	logic [ROW_W-1:0]   off_q;
	logic [RANK_W-1:0]  rk_q;
	logic [RANKS_W-1:0] nr_q;

	logic               cfg_wr;
	logic [2:0]         cfg_idx;
	logic               req_acc;
	logic [IVL_W-1:0]   icnt_nxt;
	logic               ivl_hit;
	logic               div_start;
	logic [ROW_W-1:0]   div_dvd;
	logic [DIVS_W-1:0]  div_dvs;
	wtpr_div_res_t      div_res;
	logic [BW-1:0]      blk_sat;
	logic [ROW_W-1:0]   ram_rdata;
	logic [ROW_W-1:0]   cur_high;
	logic               ram_we;
	logic [RANKS_W-1:0] ranks_eff;
	logic [DIVS_W-1:0]  slot_inc;
	logic [ROW_W-1:0]   slot_nxt;
	logic               is_last;

	// Configuration decode.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivl_q    <= IVL_W'(6240);
			nranks_q <= RANKS_W'(1);
			nrows_q  <= DIVS_W'(65536);
			rpb_q    <= DIVS_W'(16384);
			chan_q   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_INTERVAL:  ivl_q    <= pwdata[IVL_W-1:0];
				REG_NUM_RANKS: nranks_q <= pwdata[RANKS_W-1:0];
				REG_NUM_ROWS:  nrows_q  <= pwdata[DIVS_W-1:0];
				REG_ROWS_BLK:  rpb_q    <= pwdata[DIVS_W-1:0];
				REG_CHANNEL:   chan_q   <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (cfg_idx)
			REG_INTERVAL:  prdata = DATA_W'(ivl_q);
			REG_NUM_RANKS: prdata = DATA_W'(nranks_q);
			REG_NUM_ROWS:  prdata = DATA_W'(nrows_q);
			REG_ROWS_BLK:  prdata = DATA_W'(rpb_q);
			REG_CHANNEL:   prdata = DATA_W'(chan_q);
			default:       prdata = '0;
		endcase
	end

	// Input acceptance and interval counting.
	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign icnt_nxt  = icnt_q + 1'b1;
	assign ivl_hit   = (icnt_nxt == ivl_q);

	// Divider launch: the row for an access, the current slot for a refresh.
	assign div_start = req_acc && ((op == OP_ACCESS) || ivl_hit);
	assign div_dvd   = (op == OP_ACCESS) ? row : slot_q;
	assign div_dvs   = (rpb_q == '0) ? DIVS_W'(1) : rpb_q;

	wtpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.res      (div_res)
	);

	// A block number past the table falls into the last block.
	assign blk_sat = (div_res.quot >= ROW_W'(NUM_BLOCKS)) ? BW'(NUM_BLOCKS - 1)
	                                                        : div_res.quot[BW-1:0];

	// High-offset tracking RAM, read at the working block.
	wtpr_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (blk_q),
		.wdata (off_q),
		.raddr (blk_q),
		.rdata (ram_rdata)
	);

	assign cur_high = vld_q[blk_q] ? ram_rdata : '0;
	assign ram_we   = (state_q == ST_CHECK) && (op_q == OP_ACCESS) && (off_q > cur_high);

	// Commands per opportunity and next slot.
	assign ranks_eff = (nranks_q > RANKS_W'(RANK_CAP)) ? RANKS_W'(RANK_CAP) : nranks_q;
	assign slot_inc  = {1'b0, slot_q} + 1'b1;
	assign slot_nxt  = ((slot_inc >= nrows_q) || slot_inc[DIVS_W-1]) ? '0
	                                                                  : slot_inc[ROW_W-1:0];

	// Command word outputs.
	assign is_last   = (({1'b0, rk_q} + 1'b1) == nr_q);
	assign ref_valid = (state_q == ST_EMIT);
	assign channel   = chan_q;
	assign rank      = rk_q;
	assign last      = is_last;

	// Sequencer and scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			icnt_q  <= '0;
			slot_q  <= '0;
			vld_q   <= '0;
			rk_q    <= '0;
			nr_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (op == OP_ACCESS) begin
							state_q <= ST_DIV;
						end else begin
							icnt_q <= ivl_hit ? '0 : icnt_nxt;
							if (ivl_hit) begin
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (op_q == OP_ACCESS) begin
						if (ram_we) begin
							vld_q[blk_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						slot_q <= slot_nxt;
						if ((off_q <= cur_high) && (ranks_eff != '0)) begin
							rk_q    <= '0;
							nr_q    <= ranks_eff;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (ref_ready) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							rk_q <= rk_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the word in flight.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q <= op;
		end
		if ((state_q == ST_DIV) && div_res.done) begin
			blk_q <= blk_sat;
			off_q <= div_res.rem;
		end
	end

endmodule

`default_nettype wire

// ===== bench/write_tracking_partial_refresh_unit_test.sv =====
// ----------------------------------------------------------------------------
// write_tracking_partial_refresh_unit_test
// Self-checking bench for the partial refresh unit. It drives tick and access
// words and register writes, predicts every refresh command word in step with
// the accepted inputs, and compares the command words field by field.
// ----------------------------------------------------------------------------
module write_tracking_partial_refresh_unit_test
	import wtpr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_BLOCKS    = 4;
	localparam int unsigned MAX_RANKS     = 8;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT   = 200_000;
	localparam int unsigned HOLD_STRETCH  = 300;
	localparam int unsigned REG_SLOTS     = 8;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [RANK_W-1:0] rank;
		logic              last;
	} refresh_cmd_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              req_valid;
	logic              req_ready;
	logic              op;
	logic [ROW_W-1:0]  row;
	logic              ref_valid;
	logic              ref_ready;
	logic [CHAN_W-1:0] channel;
	logic [RANK_W-1:0] rank;
	logic              last;

	// Predicted register file and scheduler state.
	logic [IVL_W-1:0]   cfg_interval = 16'd6240;
	logic [RANKS_W-1:0] cfg_ranks    = 4'd1;
	logic [DIVS_W-1:0]  cfg_num_rows = 18'd65536;
	logic [DIVS_W-1:0]  cfg_rows_blk = 18'd16384;
	logic [CHAN_W-1:0]  cfg_channel  = 4'd0;
	logic [IVL_W-1:0]   tick_count   = '0;
	logic [ROW_W-1:0]   slot_ptr     = '0;
	logic [ROW_W-1:0]   high_offset [NUM_BLOCKS];

	refresh_cmd_t refresh_due [$];

	bit          send_idle      = 1'b1;
	bit          sink_idle      = 1'b1;
	int unsigned hold_cycles    = 0;
	int unsigned words_sent     = 0;
	int unsigned accesses_sent  = 0;
	int unsigned cmds_seen      = 0;
	int unsigned settings_used  = 0;
	int unsigned fail_count     = 0;
	int unsigned cycle_count    = 0;

	write_tracking_partial_refresh_unit #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.MAX_RANKS (MAX_RANKS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.op       (op),
		.row      (row),
		.ref_valid(ref_valid),
		.ref_ready(ref_ready),
		.channel  (channel),
		.rank     (rank),
		.last     (last)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Predict the refresh commands caused by one accepted word.
	function automatic void predict_refresh(input logic kind, input logic [ROW_W-1:0] addr);
		int unsigned bsize;
		int unsigned blk;
		int unsigned offs;
		int unsigned ranks;
		int unsigned nxt;
		refresh_cmd_t cmd;
		bsize = (cfg_rows_blk == 0) ? 1 : cfg_rows_blk;
		if (kind == OP_ACCESS) begin
			blk  = addr / bsize;
			offs = addr % bsize;
			if (blk >= NUM_BLOCKS) blk = NUM_BLOCKS - 1;
			if (offs > high_offset[blk]) high_offset[blk] = ROW_W'(offs);
		end else begin
			tick_count = tick_count + 1'b1;
			if (tick_count == cfg_interval) begin
				tick_count = '0;
				blk  = slot_ptr / bsize;
				offs = slot_ptr % bsize;
				if (blk >= NUM_BLOCKS) blk = NUM_BLOCKS - 1;
				if (offs <= high_offset[blk]) begin
					ranks = cfg_ranks;
					if (ranks > MAX_RANKS) ranks = MAX_RANKS;
					if (ranks > RANK_LIMIT) ranks = RANK_LIMIT;
					for (int unsigned r = 0; r < ranks; r++) begin
						cmd.chan = cfg_channel;
						cmd.rank = r[RANK_W-1:0];
						cmd.last = (r + 1 == ranks);
						refresh_due.push_back(cmd);
					end
				end
				// The slot wraps at num_rows or at the top of its 17 bits.
				nxt = slot_ptr + 1;
				if (nxt >= cfg_num_rows || nxt > (1 << ROW_W) - 1) nxt = 0;
				slot_ptr = nxt[ROW_W-1:0];
			end
		end
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// Offer one word, with a random gap ahead of it when gaps are enabled, and predict its results.
	task automatic send_word(input logic kind, input logic [ROW_W-1:0] addr);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		op        <= kind;
		row       <= addr;
		do @(posedge clk); while (!req_ready);
		predict_refresh(kind, addr);
		words_sent++;
		if (kind == OP_ACCESS) accesses_sent++;
	endtask

	// Drop the input and wait until the block has nothing left in work.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (refresh_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: a setup phase, then an access phase until pready.
	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_INTERVAL:  cfg_interval = data[IVL_W-1:0];
			REG_NUM_RANKS: cfg_ranks    = data[RANKS_W-1:0];
			REG_NUM_ROWS:  cfg_num_rows = data[DIVS_W-1:0];
			REG_ROWS_BLK:  cfg_rows_blk = data[DIVS_W-1:0];
			REG_CHANNEL:   cfg_channel  = data[CHAN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// One register read, checked against the predicted register value.
	task automatic read_reg(input logic [2:0] idx, input logic [DATA_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch($sformatf("register %0d read %0d expected %0d",
				idx, prdata, want));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write every register once the block is idle; upper bits carry noise.
	// A running tick count is first brought back to zero with one tick, so
	// that a short new interval is reached without a counter wrap.
	task automatic configure(input int unsigned ivl, input int unsigned ranks,
			input int unsigned rows_total, input int unsigned rows_blk,
			input int unsigned chan);
		logic [IVL_W-1:0] ivl_align;
		settle();
		if (tick_count != '0) begin
			ivl_align = tick_count + 1'b1;
			write_reg(REG_INTERVAL, DATA_W'(ivl_align));
			send_word(OP_TICK, ROW_W'($urandom()));
			settle();
		end
		write_reg(REG_INTERVAL,  ($urandom() << IVL_W)   | ivl);
		write_reg(REG_NUM_RANKS, ($urandom() << RANKS_W) | ranks);
		write_reg(REG_NUM_ROWS,  ($urandom() << DIVS_W)  | rows_total);
		write_reg(REG_ROWS_BLK,  ($urandom() << DIVS_W)  | rows_blk);
		write_reg(REG_CHANNEL,   ($urandom() << CHAN_W)  | chan);
		settings_used++;
	endtask

	// Random mix of ticks and accesses, mostly inside the configured rows.
	task automatic random_words(input int unsigned count, input bit with_idle);
		int unsigned span;
		logic [ROW_W-1:0] addr;
		send_idle = with_idle;
		sink_idle = with_idle;
		span = (cfg_num_rows == 0) ? 1 : cfg_num_rows;
		if (span > (1 << ROW_W)) span = 1 << ROW_W;
		repeat (count) begin
			if ($urandom_range(0, 3) == 0) addr = ROW_W'($urandom());
			else addr = ROW_W'($urandom_range(0, span - 1));
			send_word(($urandom_range(0, 9) < 6) ? OP_TICK : OP_ACCESS, addr);
		end
	endtask

	// Registers read back their reset values; accesses alone give no command.
	task automatic test_reset_defaults();
		read_reg(REG_INTERVAL,  DATA_W'(cfg_interval));
		read_reg(REG_NUM_RANKS, DATA_W'(cfg_ranks));
		read_reg(REG_NUM_ROWS,  DATA_W'(cfg_num_rows));
		read_reg(REG_ROWS_BLK,  DATA_W'(cfg_rows_blk));
		read_reg(REG_CHANNEL,   DATA_W'(cfg_channel));
		send_idle = 1'b1;
		send_word(OP_ACCESS, 17'd16385);
		send_word(OP_ACCESS, 17'd70000);
		send_word(OP_ACCESS, '1);
		send_word(OP_ACCESS, '0);
	endtask

	// Short directed sequence: field extremes, both operations, saturation.
	task automatic test_directed();
		send_idle = 1'b1;
		configure(2, 3, 8, 2, 10);
		// Writes to unused register indexes must change nothing.
		for (int unsigned i = REG_CHANNEL + 1; i < REG_SLOTS; i++)
			write_reg(i[2:0], $urandom());
		send_word(OP_ACCESS, '0);
		send_word(OP_ACCESS, '1);
		send_word(OP_TICK, '1);
		send_word(OP_TICK, '0);
		send_word(OP_ACCESS, 17'd1);
		send_word(OP_ACCESS, 17'd5);
		repeat (8) send_word(OP_TICK, ROW_W'($urandom()));
		send_word(OP_ACCESS, 17'd3);
		repeat (4) send_word(OP_TICK, ROW_W'($urandom()));
		// Saturated rank count, zero row count and zero block size.
		configure(1, 15, 0, 0, 15);
		repeat (4) send_word(OP_TICK, ROW_W'($urandom()));
	endtask

	// Random words across several register settings, extremes included.
	task automatic test_random();
		configure(1, 8, 16, 4, 15);
		random_words(30, 1'b1);
		configure(3, 15, 131072, 0, 0);
		random_words(25, 1'b1);
		configure(2, 0, 0, 131072, 9);
		random_words(20, 1'b0);
		configure(1, 1, 1, 1, 5);
		random_words(20, 1'b1);
		configure(65535, 2, 100, 30, 12);
		random_words(15, 1'b1);
		repeat (3) begin
			configure($urandom_range(1, 4), $urandom_range(0, 15), $urandom_range(0, 64),
				$urandom_range(0, 20), $urandom_range(0, 15));
			random_words(15, 1'b1);
		end
		sink_idle = 1'b1;
	endtask

	// The consumer stops for a long stretch while ticks keep coming.
	task automatic test_backpressure();
		configure(1, 8, 64, 0, 7);
		send_idle   = 1'b0;
		hold_cycles = HOLD_STRETCH;
		repeat (24) send_word(OP_TICK, ROW_W'($urandom()));
		send_idle = 1'b1;
	endtask

	// A new interval applies to the running count, which a write leaves alone.
	task automatic test_interval_change();
		configure(6, 2, 50, 5, 1);
		send_idle = 1'b0;
		repeat (4) send_word(OP_TICK, ROW_W'($urandom()));
		settle();
		write_reg(REG_INTERVAL, 32'd8);
		repeat (6) send_word(OP_TICK, ROW_W'($urandom()));
		settle();
		write_reg(REG_INTERVAL, 32'd3);
		repeat (3) send_word(OP_TICK, ROW_W'($urandom()));
		send_idle = 1'b1;
	endtask

	// Consumer: random stalls per word, or one long hold when requested.
	initial begin : command_sink
		int unsigned stall;
		ref_ready = 1'b0;
		forever begin
			if (hold_cycles != 0) begin
				stall       = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = sink_idle ? $urandom_range(0, 9) : 0;
			end
			@(negedge clk);
			if (stall != 0) begin
				ref_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			ref_ready <= 1'b1;
			do @(posedge clk); while (!ref_valid);
		end
	end

	// Compare each accepted command word with the oldest prediction.
	always @(posedge clk) begin
		refresh_cmd_t want;
		if (arst_n && ref_valid && ref_ready) begin
			cmds_seen++;
			if (refresh_due.size() == 0) begin
				report_mismatch($sformatf("unexpected command ch %0d rank %0d last %0d",
					channel, rank, last));
			end else begin
				want = refresh_due.pop_front();
				if (channel !== want.chan)
					report_mismatch($sformatf("channel got %0d expected %0d",
						channel, want.chan));
				if (rank !== want.rank)
					report_mismatch($sformatf("rank got %0d expected %0d", rank, want.rank));
				if (last !== want.last)
					report_mismatch($sformatf("last got %0d expected %0d rank %0d",
						last, want.last, want.rank));
			end
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("== FAIL ==");
		$finish;
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin : main_sequence
		for (int unsigned i = 0; i < NUM_BLOCKS; i++) high_offset[i] = '0;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		op        = OP_TICK;
		row       = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed();
		test_random();
		test_backpressure();
		test_interval_change();
		settle();

		$display("Run covered %0d input words (%0d accesses) and %0d refresh commands",
			words_sent, accesses_sent, cmds_seen);
		$display("over %0d register settings, with a long output stall and interval changes.",
			settings_used);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== write_tracking_partial_refresh_unit.f =====
rtl/core/wtpr_pkg.sv
rtl/core/wtpr_ram.sv
rtl/core/wtpr_div.sv
rtl/core/write_tracking_partial_refresh_unit.sv
bench/write_tracking_partial_refresh_unit_test.sv
